[rtl/lkr_pkg.sv]
package lkr_pkg;

  localparam int NumLayers    = 4;
  localparam int KeyPositions = 128;
  localparam int LayerW       = (NumLayers > 1) ? $clog2(NumLayers) : 1;
  localparam int PosW         = (KeyPositions > 1) ? $clog2(KeyPositions) : 1;
  localparam int KmDepth      = NumLayers * KeyPositions;
  localparam int KmAddrW      = (KmDepth > 1) ? $clog2(KmDepth) : 1;
  localparam int CodeW        = 16;
  localparam int CfgW         = 16;
  localparam int CfgIdxW      = 2;

  localparam logic [7:0]       BasicPrefixRst  = 8'h00;
  localparam logic [7:0]       MomPrefixRst    = 8'h51;
  localparam logic [CodeW-1:0] TranspCodeRst   = 16'h0001;
  localparam logic [CodeW-1:0] NoneCodeRst     = 16'h0000;

  typedef enum logic [1:0] {
    FN_WRITE = 2'd0,
    FN_DOWN  = 2'd1,
    FN_UP    = 2'd2,
    FN_TICK  = 2'd3
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BASIC_PREFIX = 2'd0,
    CFG_MOM_PREFIX   = 2'd1,
    CFG_TRANSP_CODE  = 2'd2,
    CFG_NONE_CODE    = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    ACT_ADD    = 1'b0,
    ACT_REMOVE = 1'b1
  } act_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LAST,
    ST_DECIDE,
    ST_EMIT
  } state_e;

  function automatic logic [KmAddrW-1:0] km_addr(logic [LayerW-1:0] layer,
                                                logic [PosW-1:0] pos);
    km_addr = KmAddrW'(int'(layer) * KeyPositions + int'(pos));
  endfunction

endpackage

[rtl/lkr_ram.sv]
module lkr_ram #(
  parameter int Width = 16,
  parameter int Depth = 512
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                           rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/layered_keymap_resolver.sv]
// Channel  Handshake                  Payload
// in       in_valid_i / in_ready_o    func_i, layer_index_i, key_pos_i, entry_code_i
// out      out_valid_o / out_ready_i  action_o, hid_code_o, last_o
// cfg      cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// Keymap writes, ticks and out-of-range events are taken while the block stays idle.
// A key event reads each layer once from the keymap RAM (one read port, one layer
// a cycle), then passes ST_LAST and ST_DECIDE; a basic key up then walks each layer
// in ST_EMIT from the top down; basic keys hold their state while the output is stalled.
// Reset clears control, config and current layer; the keymap RAM is not cleared.
module layered_keymap_resolver
  import lkr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         func_i,
  input  logic [1:0]         layer_index_i,
  input  logic [6:0]         key_pos_i,
  input  logic [15:0]        entry_code_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               action_o,
  output logic [7:0]         hid_code_o,
  output logic               last_o
);

  state_e state_q, state_d;

  logic [7:0]       basic_q, mom_q;
  logic [CodeW-1:0] transp_q, none_q;

  logic [LayerW-1:0] act_layer_q, act_layer_d;
  logic [LayerW-1:0] cnt_q, cnt_d;
  logic [LayerW-1:0] id_q, id_d;
  logic [LayerW-1:0] rd_lyr_q;
  logic              rd_pend_q;
  func_e             func_q;
  logic [PosW-1:0]   pos_q;

  logic [CodeW-1:0]  prev_q, code_q, res_code;
  logic [7:0]        hid_q [NumLayers];
  logic [NumLayers-1:0] mask_q;

  logic              out_valid_q, out_act_q, out_last_q;
  logic [7:0]        out_hid_q;
  logic              load;
  logic              load_act, load_last;
  logic [7:0]        load_hid;

  logic              in_acc, out_free, pos_ok, layer_ok, is_event;
  logic              ram_we;
  logic [CodeW-1:0]  ram_rdata;
  logic              lower_any;
  logic              code_basic, code_mom;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign pos_ok     = 32'(key_pos_i) < KeyPositions;
  assign layer_ok   = 32'(layer_index_i) < NumLayers;
  assign is_event   = (func_i == FN_DOWN) || (func_i == FN_UP);
  assign ram_we     = in_acc && (func_i == FN_WRITE) && pos_ok && layer_ok;

  lkr_ram #(
    .Width(CodeW),
    .Depth(KmDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (km_addr(LayerW'(layer_index_i), PosW'(key_pos_i))),
    .wdata_i (entry_code_i),
    .re_i    (state_q == ST_READ),
    .raddr_i (km_addr(cnt_q, pos_q)),
    .rdata_o (ram_rdata)
  );

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      basic_q  <= BasicPrefixRst;
      mom_q    <= MomPrefixRst;
      transp_q <= TranspCodeRst;
      none_q   <= NoneCodeRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_BASIC_PREFIX: basic_q  <= cfg_wdata_i[7:0];
        CFG_MOM_PREFIX:   mom_q    <= cfg_wdata_i[7:0];
        CFG_TRANSP_CODE:  transp_q <= cfg_wdata_i;
        CFG_NONE_CODE:    none_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // resolution walks layers upward: a transparent entry inherits the layer below
  assign res_code = (ram_rdata != transp_q) ? ram_rdata :
                    (rd_lyr_q == '0) ? none_q : prev_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q <= func_e'(func_i);
      pos_q  <= PosW'(key_pos_i);
    end
    if (rd_pend_q) begin
      prev_q           <= res_code;
      hid_q[rd_lyr_q]  <= res_code[7:0];
      mask_q[rd_lyr_q] <= (res_code[15:8] == basic_q);
      if (rd_lyr_q == act_layer_q) begin
        code_q <= res_code;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
      rd_lyr_q  <= '0;
    end else begin
      rd_pend_q <= (state_q == ST_READ);
      rd_lyr_q  <= cnt_q;
    end
  end

  always_comb begin
    lower_any = 1'b0;
    for (int j = 0; j < NumLayers; j++) begin
      lower_any = lower_any | (mask_q[j] && (LayerW'(j) < id_q));
    end
  end

  assign code_basic = (code_q[15:8] == basic_q);
  assign code_mom   = (code_q[15:8] == mom_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      id_q        <= '0;
      act_layer_q <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      id_q        <= id_d;
      act_layer_q <= act_layer_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    id_d        = id_q;
    act_layer_d = act_layer_q;
    load        = 1'b0;
    load_act    = ACT_ADD;
    load_hid    = code_q[7:0];
    load_last   = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && is_event && pos_ok) begin
          cnt_d   = '0;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LayerW'(NumLayers - 1)) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (code_basic) begin
          if (func_q == FN_DOWN) begin
            if (out_free) begin
              load    = 1'b1;
              state_d = ST_IDLE;
            end
          end else begin
            id_d    = LayerW'(NumLayers - 1);
            state_d = ST_EMIT;
          end
        end else begin
          if (code_mom) begin
            if (func_q == FN_DOWN) begin
              if (32'(code_q[7:0]) < NumLayers) begin
                act_layer_d = LayerW'(code_q[7:0]);
              end
            end else begin
              act_layer_d = '0;
            end
          end
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        load_act  = ACT_REMOVE;
        load_hid  = hid_q[id_q];
        load_last = !lower_any;
        if (out_free) begin
          load = mask_q[id_q];
          if (id_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            id_d = id_q - 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_act_q  <= load_act;
      out_hid_q  <= load_hid;
      out_last_q <= load_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign action_o    = out_act_q;
  assign hid_code_o  = out_hid_q;
  assign last_o      = out_last_q;

  a_layer_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(act_layer_q) < NumLayers)
    else $error("current layer out of range");

  a_event_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_event && pos_ok) |=> !in_ready_o)
    else $error("ready while resolving a key event");

  a_read_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> (state_q == ST_READ || state_q == ST_LAST))
    else $error("keymap read data outside the layer walk");

  a_no_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_READ) |-> !load)
    else $error("result loaded before resolution finished");

endmodule
